// ===== design/pcat_pkg.sv =====
// shared types and constants for the pair co-occurrence affinity table
package pcat_pkg;

  localparam int OP_W     = 3;
  localparam int LAYER_W  = 3;
  localparam int ID_W     = 5;
  localparam int Q_W      = 17;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam int RESULT_LIMIT = 32;
  localparam int NFOUND_W = 6;
  localparam int DIV_CNT_W = 5;

  localparam logic [OP_W-1:0] OP_BEGIN  = 3'd0;
  localparam logic [OP_W-1:0] OP_DRAFT  = 3'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 3'd2;
  localparam logic [OP_W-1:0] OP_TARGET = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DRAFT  = 2'd1;
  localparam logic [1:0] PH_TARGET = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DRAFT_IN_USE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYERS_IN_USE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_THRESHOLD = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   target_id;
    logic [Q_W-1:0]    probability;
    logic              found;
    logic              last;
  } res_t;

endpackage

// ===== design/pcat_ram.sv =====
// generic single write port ram with registered read
module pcat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pair_cooccurrence_affinity_table.sv =====
// top level of the pair co-occurrence affinity table
//
// Requests enter on the in_ stream; each is taken only while the block is idle.
// Begin, draft, flush and undefined requests pass through the emit state, which
// moves their result into the output register once it can take it; the block
// then goes back to idle. A target request walks its layer's draft list, with a
// list read, a count read and a count write back for each listed id.
// A query first sums its row, then per candidate does one selection scan of the
// row and a 17-step restoring division for the Q16 probability; the number of
// targets in use sets the scan length. Results come out in descending count
// order, lower id first on a tie, tlast on the final one of each request; at
// most 32 entries per query.
// A result waits in the output register while out_tready is low; when the next
// result is ready and that register is still full, the block holds it and takes
// no new request until the register frees.
// After reset the count memory is cleared one entry a cycle, all
// LAYER_COUNT*NUM_DRAFT*NUM_TARGET entries (8192 at the defaults); in_tready
// stays low meanwhile, configuration writes are taken at any time.
module pair_cooccurrence_affinity_table #(
  parameter int LAYER_COUNT = 8,
  parameter int NUM_DRAFT  = 32,
  parameter int NUM_TARGET = 32,
  parameter int MAX_GROUP  = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // layer[2:0], expert_id[7:3], query_threshold[24:8]
  input  logic [3:0]  in_tuser,   // op[2:0], use_own_threshold[3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // target_id[4:0], probability[21:5]
  output logic [2:0]  out_tuser,  // status[1:0], found[2]
  output logic        out_tlast
);

  localparam int CDEPTH = LAYER_COUNT * NUM_DRAFT * NUM_TARGET;
  localparam int CA_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int LDEPTH = LAYER_COUNT * MAX_GROUP;
  localparam int LA_W   = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int LEN_W  = $clog2(MAX_GROUP + 1);
  localparam int TW     = $clog2(NUM_TARGET + 1);
  localparam int TIDW   = $clog2(NUM_TARGET);
  localparam int DW     = $clog2(NUM_DRAFT + 1);
  localparam int TOT_W  = COUNT_BITS + $clog2(NUM_TARGET);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EMIT  = 4'd2;
  localparam logic [3:0] S_TL    = 4'd3;
  localparam logic [3:0] S_TD    = 4'd4;
  localparam logic [3:0] S_TW    = 4'd5;
  localparam logic [3:0] S_QTOT  = 4'd6;
  localparam logic [3:0] S_QSCAN = 4'd7;
  localparam logic [3:0] S_QDIV  = 4'd8;
  localparam logic [3:0] S_QFIN  = 4'd9;

  // configuration
  logic [5:0]  cfg_nd_r, cfg_nt_r;
  logic [3:0]  cfg_nl_r;
  logic [16:0] cfg_thr_r;

  // control and datapath registers
  logic [3:0]             state_r, state_nxt;
  logic [CA_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic [LEN_W-1:0]       len_r [LAYER_COUNT];
  logic [LEN_W-1:0]       len_nxt [LAYER_COUNT];
  logic [pcat_pkg::LAYER_W-1:0] lay_r, lay_nxt;
  logic [pcat_pkg::ID_W-1:0]    eid_r, eid_nxt;
  logic [pcat_pkg::Q_W-1:0]     thr_r, thr_nxt;
  logic [LEN_W-1:0]       k_r, k_nxt;
  logic [CA_W-1:0]        cell_r, cell_nxt;
  logic [TW-1:0]          t_r, t_nxt;
  logic                   sv_r, sv_nxt;
  logic [TIDW-1:0]        stid_r, stid_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic                   best_v_r, best_v_nxt;
  logic [COUNT_BITS-1:0]  best_c_r, best_c_nxt;
  logic [TIDW-1:0]        best_id_r, best_id_nxt;
  logic                   prev_v_r, prev_v_nxt;
  logic [COUNT_BITS-1:0]  prev_c_r, prev_c_nxt;
  logic [TIDW-1:0]        prev_id_r, prev_id_nxt;
  logic [pcat_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [TOT_W:0]         rem_r, rem_nxt;
  logic [pcat_pkg::Q_W-1:0] quo_r, quo_nxt;
  logic                   held_v_r, held_v_nxt;
  logic [TIDW-1:0]        held_id_r, held_id_nxt;
  logic [pcat_pkg::Q_W-1:0] held_p_r, held_p_nxt;
  logic [pcat_pkg::NFOUND_W-1:0] nfound_r, nfound_nxt;
  pcat_pkg::res_t         pend_r, pend_nxt;
  logic [3:0]             ret_r, ret_nxt;
  pcat_pkg::res_t         out_r, out_nxt;
  logic                   out_v_r, out_v_nxt;

  // memory ports
  logic                   cnt_we;
  logic [CA_W-1:0]        cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0]  cnt_wdata, cnt_rd;
  logic                   lst_we;
  logic [LA_W-1:0]        lst_waddr, lst_raddr;
  logic [pcat_pkg::ID_W-1:0] lst_rd;

  // request fields
  logic [pcat_pkg::OP_W-1:0]    in_op;
  logic [pcat_pkg::LAYER_W-1:0] in_layer;
  logic [pcat_pkg::ID_W-1:0]    in_id;
  logic [pcat_pkg::Q_W-1:0]     in_qthr;
  logic                         in_own;

  assign in_layer = in_tdata[2:0];
  assign in_id    = in_tdata[7:3];
  assign in_qthr  = in_tdata[24:8];
  assign in_op    = in_tuser[2:0];
  assign in_own   = in_tuser[3];

  logic [TW-1:0] nt_cl;
  logic [DW-1:0] nd_cl;
  logic          layer_ok, draft_ok, target_ok;
  logic [LEN_W-1:0] in_len, cur_len;

  assign nt_cl = (int'(cfg_nt_r) > NUM_TARGET) ? TW'(NUM_TARGET) : TW'(cfg_nt_r);
  assign nd_cl = (int'(cfg_nd_r) > NUM_DRAFT) ? DW'(NUM_DRAFT) : DW'(cfg_nd_r);
  assign layer_ok  = (int'(in_layer) < int'(cfg_nl_r)) && (int'(in_layer) < LAYER_COUNT);
  assign draft_ok  = int'(in_id) < int'(nd_cl);
  assign target_ok = int'(in_id) < int'(nt_cl);

  always_comb begin
    in_len  = '0;
    cur_len = '0;
    for (int i = 0; i < LAYER_COUNT; i++) begin
      if (int'(in_layer) == i) begin
        in_len = len_r[i];
      end
      if (int'(lay_r) == i) begin
        cur_len = len_r[i];
      end
    end
  end

  // row scan shared by total and selection passes
  logic          scan_issue, scan_done;
  logic [CA_W-1:0] row_addr;
  logic          elig, better, div_ge, qual;
  logic [TOT_W:0] rem_sub;
  logic [pcat_pkg::Q_W-1:0] quo_step;

  assign scan_issue = t_r < nt_cl;
  assign scan_done  = !scan_issue && !sv_r;
  assign row_addr   = CA_W'((int'(lay_r) * NUM_DRAFT + int'(eid_r)) * NUM_TARGET + int'(t_r));

  // next in order: below the previous entry by count, or equal count and higher id
  assign elig = (cnt_rd != '0) &&
                (!prev_v_r || (cnt_rd < prev_c_r) || ((cnt_rd == prev_c_r) && (stid_r > prev_id_r)));
  assign better = !best_v_r || (cnt_rd > best_c_r);

  assign div_ge   = rem_r >= {1'b0, total_r};
  assign rem_sub  = div_ge ? (rem_r - {1'b0, total_r}) : rem_r;
  assign quo_step = {quo_r[pcat_pkg::Q_W-2:0], div_ge};
  assign qual     = quo_step >= thr_r;

  logic out_free;
  assign out_free = !out_v_r || out_tready;

  always_comb begin
    state_nxt   = state_r;
    clr_addr_nxt = clr_addr_r;
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    lay_nxt     = lay_r;
    eid_nxt     = eid_r;
    thr_nxt     = thr_r;
    k_nxt       = k_r;
    cell_nxt    = cell_r;
    t_nxt       = t_r;
    sv_nxt      = 1'b0;
    stid_nxt    = stid_r;
    total_nxt   = total_r;
    best_v_nxt  = best_v_r;
    best_c_nxt  = best_c_r;
    best_id_nxt = best_id_r;
    prev_v_nxt  = prev_v_r;
    prev_c_nxt  = prev_c_r;
    prev_id_nxt = prev_id_r;
    div_cnt_nxt = div_cnt_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    held_v_nxt  = held_v_r;
    held_id_nxt = held_id_r;
    held_p_nxt  = held_p_r;
    nfound_nxt  = nfound_r;
    pend_nxt    = pend_r;
    ret_nxt     = ret_r;
    out_nxt     = out_r;
    out_v_nxt   = out_v_r && !out_tready;
    cnt_we      = 1'b0;
    cnt_waddr   = cell_r;
    cnt_wdata   = (cnt_rd == CNT_MAX) ? cnt_rd : (cnt_rd + 1'b1);
    cnt_raddr   = row_addr;
    lst_we      = 1'b0;
    lst_waddr   = LA_W'(int'(in_layer) * MAX_GROUP + int'(in_len));
    lst_raddr   = LA_W'(int'(lay_r) * MAX_GROUP + int'(k_r));

    if ((state_r == S_QTOT) || (state_r == S_QSCAN)) begin
      if (scan_issue) begin
        t_nxt    = t_r + 1'b1;
        sv_nxt   = 1'b1;
        stid_nxt = t_r[TIDW-1:0];
      end
    end

    unique case (state_r)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr_r;
        cnt_wdata = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (int'(clr_addr_r) == CDEPTH - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          lay_nxt  = in_layer;
          eid_nxt  = in_id;
          thr_nxt  = in_own ? in_qthr : cfg_thr_r;
          k_nxt    = '0;
          pend_nxt = '{status: pcat_pkg::ST_DONE, target_id: '0, probability: '0,
                       found: 1'b0, last: 1'b1};
          ret_nxt  = S_IDLE;
          state_nxt = S_EMIT;
          unique case (in_op)
            pcat_pkg::OP_BEGIN: begin
              phase_nxt = pcat_pkg::PH_DRAFT;
              for (int i = 0; i < LAYER_COUNT; i++) begin
                len_nxt[i] = '0;
              end
            end
            pcat_pkg::OP_DRAFT: begin
              if (phase_r != pcat_pkg::PH_DRAFT || !layer_ok || !draft_ok) begin
                pend_nxt.status = pcat_pkg::ST_IGNORED;
              end else if (int'(in_len) >= MAX_GROUP) begin
                pend_nxt.status = pcat_pkg::ST_FULL;
              end else begin
                lst_we = 1'b1;
                for (int i = 0; i < LAYER_COUNT; i++) begin
                  if (int'(in_layer) == i) begin
                    len_nxt[i] = len_r[i] + 1'b1;
                  end
                end
              end
            end
            pcat_pkg::OP_FLUSH: begin
              phase_nxt = pcat_pkg::PH_TARGET;
            end
            pcat_pkg::OP_TARGET: begin
              if (phase_r != pcat_pkg::PH_TARGET || !layer_ok || !target_ok) begin
                pend_nxt.status = pcat_pkg::ST_IGNORED;
              end else begin
                state_nxt = S_TL;
              end
            end
            pcat_pkg::OP_QUERY: begin
              if (!layer_ok || !draft_ok) begin
                pend_nxt.status = pcat_pkg::ST_IGNORED;
              end else begin
                state_nxt  = S_QTOT;
                t_nxt      = '0;
                total_nxt  = '0;
                prev_v_nxt = 1'b0;
                held_v_nxt = 1'b0;
                nfound_nxt = '0;
              end
            end
            default: begin
              pend_nxt.status = pcat_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_nxt   = pend_r;
          out_v_nxt = 1'b1;
          state_nxt = ret_r;
          t_nxt      = '0;
          best_v_nxt = 1'b0;
        end
      end
      S_TL: begin
        if (k_r < cur_len) begin
          state_nxt = S_TD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_TD: begin
        cell_nxt  = CA_W'((int'(lay_r) * NUM_DRAFT + int'(lst_rd)) * NUM_TARGET + int'(eid_r));
        cnt_raddr = cell_nxt;
        if (int'(lst_rd) < int'(nd_cl)) begin
          state_nxt = S_TW;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_TL;
        end
      end
      S_TW: begin
        cnt_we    = 1'b1;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_TL;
      end
      S_QTOT: begin
        if (sv_r) begin
          total_nxt = total_r + TOT_W'(cnt_rd);
        end
        if (scan_done) begin
          state_nxt  = S_QSCAN;
          t_nxt      = '0;
          best_v_nxt = 1'b0;
        end
      end
      S_QSCAN: begin
        if (sv_r && elig && better) begin
          best_v_nxt  = 1'b1;
          best_c_nxt  = cnt_rd;
          best_id_nxt = stid_r;
        end
        if (scan_done) begin
          if (best_v_r) begin
            rem_nxt     = {1'b0, TOT_W'(best_c_r)};
            quo_nxt     = '0;
            div_cnt_nxt = pcat_pkg::DIV_CNT_W'(pcat_pkg::Q_W);
            state_nxt   = S_QDIV;
          end else begin
            state_nxt = S_QFIN;
          end
        end
      end
      S_QDIV: begin
        quo_nxt     = quo_step;
        rem_nxt     = {rem_sub[TOT_W-1:0], 1'b0};
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == pcat_pkg::DIV_CNT_W'(1)) begin
          if (qual) begin
            held_v_nxt  = 1'b1;
            held_id_nxt = best_id_r;
            held_p_nxt  = quo_step;
            nfound_nxt  = nfound_r + 1'b1;
            prev_v_nxt  = 1'b1;
            prev_c_nxt  = best_c_r;
            prev_id_nxt = best_id_r;
            t_nxt       = '0;
            best_v_nxt  = 1'b0;
            ret_nxt = (int'(nfound_r) + 1 == pcat_pkg::RESULT_LIMIT) ? S_QFIN : S_QSCAN;
            if (held_v_r) begin
              pend_nxt = '{status: pcat_pkg::ST_DONE,
                           target_id: pcat_pkg::ID_W'(held_id_r),
                           probability: held_p_r, found: 1'b1, last: 1'b0};
              state_nxt = S_EMIT;
            end else begin
              state_nxt = ret_nxt;
            end
          end else begin
            state_nxt = S_QFIN;
          end
        end
      end
      S_QFIN: begin
        if (held_v_r) begin
          pend_nxt = '{status: pcat_pkg::ST_DONE, target_id: pcat_pkg::ID_W'(held_id_r),
                       probability: held_p_r, found: 1'b1, last: 1'b1};
        end else begin
          pend_nxt = '{status: pcat_pkg::ST_DONE, target_id: '0, probability: '0,
                       found: 1'b0, last: 1'b1};
        end
        ret_nxt   = S_IDLE;
        state_nxt = S_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_addr_r <= '0;
      phase_r    <= pcat_pkg::PH_IDLE;
      for (int i = 0; i < LAYER_COUNT; i++) begin
        len_r[i] <= '0;
      end
      out_v_r    <= 1'b0;
      sv_r       <= 1'b0;
      cfg_nd_r   <= 6'd32;
      cfg_nt_r   <= 6'd32;
      cfg_nl_r   <= 4'd8;
      cfg_thr_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      out_v_r    <= out_v_nxt;
      sv_r       <= sv_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pcat_pkg::REG_DRAFT_IN_USE:  cfg_nd_r  <= cfg_wdata[5:0];
          pcat_pkg::REG_TARGET_IN_USE: cfg_nt_r  <= cfg_wdata[5:0];
          pcat_pkg::REG_LAYERS_IN_USE: cfg_nl_r  <= cfg_wdata[3:0];
          pcat_pkg::REG_DEF_THRESHOLD: cfg_thr_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lay_r     <= lay_nxt;
    eid_r     <= eid_nxt;
    thr_r     <= thr_nxt;
    k_r       <= k_nxt;
    cell_r    <= cell_nxt;
    t_r       <= t_nxt;
    stid_r    <= stid_nxt;
    total_r   <= total_nxt;
    best_v_r  <= best_v_nxt;
    best_c_r  <= best_c_nxt;
    best_id_r <= best_id_nxt;
    prev_v_r  <= prev_v_nxt;
    prev_c_r  <= prev_c_nxt;
    prev_id_r <= prev_id_nxt;
    div_cnt_r <= div_cnt_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    held_v_r  <= held_v_nxt;
    held_id_r <= held_id_nxt;
    held_p_r  <= held_p_nxt;
    nfound_r  <= nfound_nxt;
    pend_r    <= pend_nxt;
    ret_r     <= ret_nxt;
    out_r     <= out_nxt;
  end

  pcat_ram #(.WIDTH(COUNT_BITS), .DEPTH(CDEPTH), .AW(CA_W)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  pcat_ram #(.WIDTH(pcat_pkg::ID_W), .DEPTH(LDEPTH), .AW(LA_W)) u_lists (
    .clk   (clk),
    .we    (lst_we),
    .waddr (lst_waddr),
    .wdata (in_id),
    .raddr (lst_raddr),
    .rdata (lst_rd)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_r.probability, out_r.target_id};
  assign out_tuser  = {out_r.found, out_r.status};
  assign out_tlast  = out_r.last;

endmodule
